// File: rtl/core/tbps_pkg.sv
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared constants, a type and a helper function of the textured shader.
// ----------------------------------------------------------------------------
package tbps_pkg;

   localparam int FB_WIDTH_DEFAULT   = 256;
   localparam int FB_HEIGHT_DEFAULT  = 256;
   localparam int MAX_LIGHTS_DEFAULT = 4;
   localparam int DEPTH_BITS_DEFAULT = 16;

   localparam int ACC_W   = 22;
   localparam int REQ_W   = 200;
   localparam int RSP_W   = 80;
   localparam int CSR_W   = 48;
   localparam int CSR_IW  = 3;

   localparam logic signed [15:0] Q14_ONE = 16'sd16384;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 22'sd2097151;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -22'sd2097152;

   // Register indexes of the configuration port.
   localparam logic [CSR_IW-1:0] CSR_LIGHT0    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_LIGHT1    = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_LIGHT2    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_LIGHT3    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_SPECULAR  = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_AMBIENT   = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_SHININESS = 3'd6;

   typedef logic signed [ACC_W-1:0] acc_type;

   // Saturating accumulate into the signed Q5.16 range.
   function automatic acc_type sat_acc(input logic signed [24:0] v);
      if (v > 25'(ACC_MAX)) begin
         return ACC_MAX;
      end else if (v < 25'(ACC_MIN)) begin
         return ACC_MIN;
      end
      return v[ACC_W-1:0];
   endfunction

endpackage

// File: rtl/core/tbps_ram.sv
// ----------------------------------------------------------------------------
// tbps_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tbps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

// File: rtl/core/tbps_isqrt.sv
// ----------------------------------------------------------------------------
// tbps_isqrt
// Iterative integer square root of a 32-bit value, two bits a cycle.
// ----------------------------------------------------------------------------
module tbps_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic [15:0] root
);

   logic [31:0] v_ff;
   logic [31:0] r_ff;
   logic [31:0] bit_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] trial;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};
   assign done  = done_ff;
   assign root  = r_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            v_ff    <= value;
            r_ff    <= 32'd0;
            bit_ff  <= 32'h4000_0000;
            cnt_ff  <= 4'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if ({1'b0, v_ff} >= trial) begin
               v_ff <= v_ff - trial[31:0];
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// File: rtl/core/tbps_div.sv
// ----------------------------------------------------------------------------
// tbps_div
// Restoring divider, one quotient bit a cycle; quotient known below 2^16.
// ----------------------------------------------------------------------------
module tbps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic [16:0] rem_ff;
   logic [15:0] low_ff;
   logic [15:0] q_ff;
   logic [15:0] d_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] trial;

   assign trial    = {rem_ff[15:0], low_ff[15]};
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= {3'b000, dividend[29:16]};
            low_ff  <= dividend[15:0];
            d_ff    <= divisor;
            q_ff    <= 16'd0;
            cnt_ff  <= 4'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, d_ff}) begin
               rem_ff <= trial - {1'b0, d_ff};
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff   <= {q_ff[14:0], 1'b0};
            end
            low_ff <= {low_ff[14:0], 1'b0};
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// File: rtl/core/textured_blinn_phong_shader.sv
// ----------------------------------------------------------------------------
// textured_blinn_phong_shader
// Per-light Blinn-Phong accumulation with texture, ambient and depth test.
// ----------------------------------------------------------------------------
// Each input item carries one light of one fragment. The block takes one item
// at a time and finishes it before it takes the next; the three vector
// normalizations dominate, each using the square root and three divisions,
// and every product goes through one shared 18x18 multiplier. An item with
// tlast set finishes the fragment: the accumulated color is clamped, ambient
// is added, and for an in-frame pixel a depth-buffer read-compare-write
// follows on the single RAM port. A passing fragment leaves as one output item
// held in an output register, so the next input item is taken while it waits.
// After reset the depth buffer is cleared to the farthest depth in a pass over
// all FB_WIDTH*FB_HEIGHT entries (65536 by default), during which no input item
// is accepted; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module textured_blinn_phong_shader #(
   parameter int FB_WIDTH   = tbps_pkg::FB_WIDTH_DEFAULT,
   parameter int FB_HEIGHT  = tbps_pkg::FB_HEIGHT_DEFAULT,
   parameter int MAX_LIGHTS = tbps_pkg::MAX_LIGHTS_DEFAULT,
   parameter int DEPTH_BITS = tbps_pkg::DEPTH_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input fields from bit 0: pixel_x, pixel_y, frag_depth, texel_rgb,
   // surface_normal, light_dir, half_dir.
   input  logic [tbps_pkg::REQ_W-1:0]  req_tdata,
   // light_index.
   input  logic [1:0]                  req_tuser,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // Output fields from bit 0: out_x, out_y, out_red, out_green, out_blue,
   // out_depth.
   output logic [tbps_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [tbps_pkg::CSR_IW-1:0] csr_index,
   input  logic [tbps_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_W   = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_SQ    = 5'd2;
   localparam logic [4:0] S_SQA   = 5'd3;
   localparam logic [4:0] S_SQS   = 5'd4;
   localparam logic [4:0] S_SQW   = 5'd5;
   localparam logic [4:0] S_DIV   = 5'd6;
   localparam logic [4:0] S_DIVW  = 5'd7;
   localparam logic [4:0] S_NEXTV = 5'd8;
   localparam logic [4:0] S_DOT   = 5'd9;
   localparam logic [4:0] S_DOTA  = 5'd10;
   localparam logic [4:0] S_DOTF  = 5'd11;
   localparam logic [4:0] S_PM    = 5'd12;
   localparam logic [4:0] S_PMA   = 5'd13;
   localparam logic [4:0] S_PS    = 5'd14;
   localparam logic [4:0] S_PSA   = 5'd15;
   localparam logic [4:0] S_LIT   = 5'd16;
   localparam logic [4:0] S_LITA  = 5'd17;
   localparam logic [4:0] S_DIF   = 5'd18;
   localparam logic [4:0] S_DIFA  = 5'd19;
   localparam logic [4:0] S_SP    = 5'd20;
   localparam logic [4:0] S_SPA   = 5'd21;
   localparam logic [4:0] S_FIN   = 5'd22;
   localparam logic [4:0] S_FINA  = 5'd23;
   localparam logic [4:0] S_RD    = 5'd24;
   localparam logic [4:0] S_CMP   = 5'd25;

   // Configuration registers.
   logic [47:0] light_ff [4];
   logic [47:0] spec_ff;
   logic [15:0] amb_ff;
   logic [7:0]  shin_ff;

   // Captured item.
   logic [7:0]  px_ff;
   logic [7:0]  py_ff;
   logic [15:0] fd_ff;
   logic [23:0] tex_ff;
   logic [47:0] vec_ff [3];
   logic [1:0]  lidx_ff;
   logic        last_ff;

   // Sequencer state.
   logic [4:0]        state_ff;
   logic [1:0]        vi_ff;
   logic [1:0]        k_ff;
   logic [1:0]        ch_ff;
   logic [2:0]        bit_ff;
   logic              dsel_ff;
   logic [31:0]       len2_ff;
   logic [15:0]       s_ff;
   logic signed [31:0] dacc_ff;
   logic signed [15:0] nrm_ff [3][3];
   logic signed [15:0] ndl_ff;
   logic signed [15:0] pow_r_ff;
   logic signed [15:0] pow_b_ff;
   logic [15:0]       lit_ff;
   tbps_pkg::acc_type acc_ff [3];
   logic [15:0]       rgb_ff [3];
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              rsp_valid_ff;
   logic [tbps_pkg::RSP_W-1:0] rsp_data_ff;

   // Shared multiplier with a registered product.
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] prod_ff;

   // Derived values.
   logic signed [15:0] comp;
   logic [29:0]        comp_mag;
   logic [15:0]        tex16;
   logic [47:0]        inten;
   logic [15:0]        spec16;
   logic signed [31:0] dot_sh;
   logic signed [15:0] dot_cl;
   logic signed [24:0] dif_sum;
   logic signed [24:0] sp_sum;
   logic [22:0]        fin_sum;
   logic [31:0]        pos32;
   logic [31:0]        fd_masked;
   logic [DEPTH_BITS-1:0] fd_dw;
   logic               in_frame;

   logic              sqrt_start;
   logic              sqrt_done;
   logic [15:0]       sqrt_root;
   logic              div_start;
   logic              div_done;
   logic [15:0]       div_q;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [DEPTH_BITS-1:0] ram_wdata;
   logic [DEPTH_BITS-1:0] ram_rdata;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign comp     = vec_ff[vi_ff][{k_ff, 4'b0000} +: 16];
   assign comp_mag = {(comp[15] ? 16'(-comp) : 16'(comp)), 14'd0};
   assign tex16    = {tex_ff[{ch_ff, 3'b000} +: 8], tex_ff[{ch_ff, 3'b000} +: 8]};
   assign inten    = (32'(lidx_ff) < MAX_LIGHTS) ? light_ff[lidx_ff] : 48'd0;
   assign spec16   = spec_ff[{ch_ff, 4'b0000} +: 16];

   assign dot_sh = dacc_ff >>> 14;
   assign dot_cl = (dot_sh > 32'sd16384)  ? tbps_pkg::Q14_ONE :
                   (dot_sh < -32'sd16384) ? -tbps_pkg::Q14_ONE : dot_sh[15:0];

   assign dif_sum = 25'(acc_ff[ch_ff]) + 25'(prod_ff >>> 14);
   assign sp_sum  = 25'(acc_ff[ch_ff]) + 25'(prod_ff >>> 14);
   assign fin_sum = (acc_ff[ch_ff][tbps_pkg::ACC_W-1] ? 23'd0 : 23'(acc_ff[ch_ff]))
                    + 23'(prod_ff[31:16]);

   assign pos32     = 32'(py_ff) * 32'(FB_WIDTH) + 32'(px_ff);
   assign fd_masked = {16'd0, fd_ff} & (32'hFFFF_FFFF >> (32 - DEPTH_BITS));
   assign fd_dw     = fd_masked[DEPTH_BITS-1:0];
   assign in_frame  = (32'(px_ff) < FB_WIDTH) && (32'(py_ff) < FB_HEIGHT);

   assign sqrt_start = (state_ff == S_SQS) && (len2_ff != 32'd0);
   assign div_start  = (state_ff == S_DIV);

   always_comb begin
      mul_a = 18'sd0;
      mul_b = 18'sd0;
      case (state_ff)
         S_SQ: begin
            mul_a = 18'(comp);
            mul_b = 18'(comp);
         end
         S_DOT: begin
            mul_a = 18'(nrm_ff[0][k_ff]);
            mul_b = dsel_ff ? 18'(nrm_ff[2][k_ff]) : 18'(nrm_ff[1][k_ff]);
         end
         S_PM: begin
            mul_a = 18'(pow_r_ff);
            mul_b = 18'(pow_b_ff);
         end
         S_PS: begin
            mul_a = 18'(pow_b_ff);
            mul_b = 18'(pow_b_ff);
         end
         S_LIT: begin
            mul_a = {2'b00, tex16};
            mul_b = {2'b00, inten[{ch_ff, 4'b0000} +: 16]};
         end
         S_DIF: begin
            mul_a = {2'b00, lit_ff};
            mul_b = 18'(ndl_ff);
         end
         S_SP: begin
            mul_a = {2'b00, spec16};
            mul_b = 18'(pow_r_ff);
         end
         S_FIN: begin
            mul_a = {2'b00, amb_ff};
            mul_b = {2'b00, tex16};
         end
         default: begin
            mul_a = 18'sd0;
            mul_b = 18'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // The depth buffer port is shared by the clearing pass and the test.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_addr  = clr_cnt_ff;
         ram_wdata = fd_masked[DEPTH_BITS-1:0] | {DEPTH_BITS{1'b1}};
      end else begin
         ram_we    = (state_ff == S_CMP) && (fd_dw < ram_rdata);
         ram_addr  = pos32[ADDR_W-1:0];
         ram_wdata = fd_dw;
      end
   end

   tbps_ram #(
      .WIDTH(DEPTH_BITS),
      .DEPTH(FB_DEPTH)
   ) u_depth_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   tbps_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(sqrt_start),
      .value(len2_ff),
      .done (sqrt_done),
      .root (sqrt_root)
   );

   tbps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(comp_mag),
      .divisor (s_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            light_ff[i] <= 48'd0;
         end
         spec_ff <= 48'd0;
         amb_ff  <= 16'd0;
         shin_ff <= 8'd32;
      end else if (csr_we) begin
         case (csr_index)
            tbps_pkg::CSR_LIGHT0:    light_ff[0] <= csr_wdata;
            tbps_pkg::CSR_LIGHT1:    light_ff[1] <= csr_wdata;
            tbps_pkg::CSR_LIGHT2:    light_ff[2] <= csr_wdata;
            tbps_pkg::CSR_LIGHT3:    light_ff[3] <= csr_wdata;
            tbps_pkg::CSR_SPECULAR:  spec_ff     <= csr_wdata;
            tbps_pkg::CSR_AMBIENT:   amb_ff      <= csr_wdata[15:0];
            tbps_pkg::CSR_SHININESS: shin_ff     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: one micro-step per state; each product is registered and arrives
   // in the cycle after the issuing state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
               if (clr_cnt_ff == ADDR_W'(FB_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  px_ff     <= req_tdata[7:0];
                  py_ff     <= req_tdata[15:8];
                  fd_ff     <= req_tdata[31:16];
                  tex_ff    <= req_tdata[55:32];
                  vec_ff[0] <= req_tdata[103:56];
                  vec_ff[1] <= req_tdata[151:104];
                  vec_ff[2] <= req_tdata[199:152];
                  lidx_ff   <= req_tuser;
                  last_ff   <= req_tlast;
                  vi_ff     <= 2'd0;
                  k_ff      <= 2'd0;
                  len2_ff   <= 32'd0;
                  state_ff  <= S_SQ;
               end
            end
            S_SQ: state_ff <= S_SQA;
            S_SQA: begin
               len2_ff <= len2_ff + prod_ff[31:0];
               if (k_ff == 2'd2) begin
                  state_ff <= S_SQS;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_SQ;
               end
            end
            S_SQS: begin
               k_ff <= 2'd0;
               if (len2_ff == 32'd0) begin
                  // A zero-length vector normalizes to the zero vector.
                  for (int i = 0; i < 3; i++) begin
                     nrm_ff[vi_ff][i] <= 16'sd0;
                  end
                  state_ff <= S_NEXTV;
               end else begin
                  state_ff <= S_SQW;
               end
            end
            S_SQW: begin
               if (sqrt_done) begin
                  s_ff     <= sqrt_root;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) begin
                  nrm_ff[vi_ff][k_ff] <= comp[15] ? 16'(-div_q) : div_q;
                  if (k_ff == 2'd2) begin
                     state_ff <= S_NEXTV;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_NEXTV: begin
               k_ff    <= 2'd0;
               len2_ff <= 32'd0;
               if (vi_ff == 2'd2) begin
                  dsel_ff  <= 1'b0;
                  dacc_ff  <= 32'sd0;
                  state_ff <= S_DOT;
               end else begin
                  vi_ff    <= vi_ff + 2'd1;
                  state_ff <= S_SQ;
               end
            end
            S_DOT: state_ff <= S_DOTA;
            S_DOTA: begin
               dacc_ff <= dacc_ff + prod_ff[31:0];
               if (k_ff == 2'd2) begin
                  state_ff <= S_DOTF;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_DOT;
               end
            end
            S_DOTF: begin
               k_ff    <= 2'd0;
               dacc_ff <= 32'sd0;
               if (!dsel_ff) begin
                  ndl_ff   <= dot_cl;
                  dsel_ff  <= 1'b1;
                  state_ff <= S_DOT;
               end else begin
                  bit_ff   <= 3'd0;
                  pow_b_ff <= dot_cl;
                  ch_ff    <= 2'd0;
                  if (dot_cl > 16'sd0) begin
                     pow_r_ff <= tbps_pkg::Q14_ONE;
                     state_ff <= S_PM;
                  end else begin
                     // No specular term when N.H is at or below zero.
                     pow_r_ff <= 16'sd0;
                     state_ff <= S_LIT;
                  end
               end
            end
            S_PM: begin
               state_ff <= shin_ff[bit_ff] ? S_PMA : S_PS;
            end
            S_PMA: begin
               pow_r_ff <= 16'(prod_ff >>> 14);
               state_ff <= S_PS;
            end
            S_PS: state_ff <= S_PSA;
            S_PSA: begin
               pow_b_ff <= 16'(prod_ff >>> 14);
               if (bit_ff == 3'd7) begin
                  ch_ff    <= 2'd0;
                  state_ff <= S_LIT;
               end else begin
                  bit_ff   <= bit_ff + 3'd1;
                  state_ff <= S_PM;
               end
            end
            S_LIT: state_ff <= S_LITA;
            S_LITA: begin
               lit_ff   <= prod_ff[31:16];
               state_ff <= S_DIF;
            end
            S_DIF: state_ff <= S_DIFA;
            S_DIFA: begin
               acc_ff[ch_ff] <= tbps_pkg::sat_acc(dif_sum);
               state_ff      <= S_SP;
            end
            S_SP: state_ff <= S_SPA;
            S_SPA: begin
               acc_ff[ch_ff] <= tbps_pkg::sat_acc(sp_sum);
               if (ch_ff == 2'd2) begin
                  ch_ff    <= 2'd0;
                  state_ff <= last_ff ? S_FIN : S_IDLE;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_LIT;
               end
            end
            S_FIN: state_ff <= S_FINA;
            S_FINA: begin
               rgb_ff[ch_ff] <= (fin_sum > 23'd65535) ? 16'hFFFF : fin_sum[15:0];
               if (ch_ff == 2'd2) begin
                  for (int i = 0; i < 3; i++) begin
                     acc_ff[i] <= '0;
                  end
                  state_ff <= in_frame ? S_RD : S_IDLE;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_FIN;
               end
            end
            S_RD: begin
               // The read is issued once the output register is free.
               if (!rsp_valid_ff) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (fd_dw < ram_rdata) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {fd_masked[15:0], rgb_ff[2], rgb_ff[1], rgb_ff[0],
                                   py_ff, px_ff};
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A new output item only appears right after a depth compare.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CMP)
      else $error("output item without a depth compare");

   // The compare always follows the read that feeds it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> $past(state_ff) == S_RD)
      else $error("depth compare without a preceding read");

   // A depth write never lands while the output register is still occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && ram_we) |-> !rsp_valid_ff)
      else $error("depth write while output item pending");

endmodule

// File: tb/shading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shading_checker
// Watches the shader's channels, predicts each pixel and compares it.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the registers, the color accumulators and
// the depth buffer. Every accepted input item is shaded here; a finishing item
// that passes the depth test queues one expected pixel, and every accepted
// output item is compared with the oldest queued pixel.
// ----------------------------------------------------------------------------
module shading_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tbps_pkg::REQ_W-1:0]  req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [tbps_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_we,
   input  logic [tbps_pkg::CSR_IW-1:0] csr_index,
   input  logic [tbps_pkg::CSR_W-1:0]  csr_wdata,
   output int                          errors,
   output int                          pending
);

   typedef struct packed {
      logic [15:0] depth;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
      logic [7:0]  y;
      logic [7:0]  x;
   } pixel_type;

   localparam longint SAT_HI = 2097151;
   localparam longint SAT_LO = -2097152;

   logic [47:0] intensity [4];
   logic [47:0] spec_rgb;
   logic [15:0] ambient;
   logic [7:0]  shine;
   longint      color_sum [3];
   logic [15:0] zbuf [65536];
   pixel_type   pixel_queue [$];

   assign pending = pixel_queue.size();

   function automatic longint int_sqrt(input longint v);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void unit_vector(input logic [47:0] p, output longint o[3]);
      longint c[3];
      longint len2;
      longint s;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         c[i] = longint'($signed(p[16*i +: 16]));
         len2 += c[i] * c[i];
      end
      if (len2 == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
      end else begin
         s = int_sqrt(len2);
         // Integer division truncates toward zero, as the hardware does.
         for (int i = 0; i < 3; i++) o[i] = (c[i] * 16384) / s;
      end
   endfunction

   function automatic longint dot_q14(input longint a[3], input longint b[3]);
      longint d;
      d = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 14;
      if (d > 16384) d = 16384;
      if (d < -16384) d = -16384;
      return d;
   endfunction

   function automatic longint clamp_acc(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   always @(posedge clock) begin
      longint nv[3], lv[3], hv[3];
      longint ndl, ndh, spec, base, lit, tex16[3], ch_out[3];
      logic [47:0] inten;
      pixel_type want, got;
      logic [15:0] depth;
      if (reset) begin
         for (int i = 0; i < 4; i++) intensity[i] = '0;
         spec_rgb = '0;
         ambient  = '0;
         shine    = 8'd32;
         for (int i = 0; i < 3; i++) color_sum[i] = 0;
         for (int i = 0; i < 65536; i++) zbuf[i] = 16'hFFFF;
         pixel_queue.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tbps_pkg::CSR_LIGHT0, tbps_pkg::CSR_LIGHT1,
               tbps_pkg::CSR_LIGHT2, tbps_pkg::CSR_LIGHT3: begin
                  intensity[csr_index[1:0]] = csr_wdata;
               end
               tbps_pkg::CSR_SPECULAR:  spec_rgb = csr_wdata;
               tbps_pkg::CSR_AMBIENT:   ambient  = csr_wdata[15:0];
               tbps_pkg::CSR_SHININESS: shine    = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            unit_vector(req_tdata[103:56], nv);
            unit_vector(req_tdata[151:104], lv);
            unit_vector(req_tdata[199:152], hv);
            ndl = dot_q14(nv, lv);
            ndh = dot_q14(nv, hv);
            spec = 0;
            // The highlight is dropped when the half vector faces away.
            if (ndh > 0) begin
               spec = 16384;
               base = ndh;
               for (int i = 0; i < 8; i++) begin
                  if (shine[i]) spec = (spec * base) >>> 14;
                  base = (base * base) >>> 14;
               end
            end
            inten = intensity[req_tuser];
            for (int c = 0; c < 3; c++) begin
               tex16[c] = longint'(req_tdata[32 + 8*c +: 8]) * 257;
               lit = (tex16[c] * longint'(inten[16*c +: 16])) >> 16;
               color_sum[c] = clamp_acc(color_sum[c] + ((lit * ndl) >>> 14));
               color_sum[c] = clamp_acc(color_sum[c]
                                        + ((longint'(spec_rgb[16*c +: 16]) * spec) >>> 14));
            end
            if (req_tlast) begin
               for (int c = 0; c < 3; c++) begin
                  ch_out[c] = (color_sum[c] < 0) ? 0 : color_sum[c];
                  ch_out[c] += (longint'(ambient) * tex16[c]) >> 16;
                  if (ch_out[c] > 65535) ch_out[c] = 65535;
                  color_sum[c] = 0;
               end
               depth = req_tdata[31:16];
               if (depth < zbuf[{req_tdata[15:8], req_tdata[7:0]}]) begin
                  zbuf[{req_tdata[15:8], req_tdata[7:0]}] = depth;
                  want.x     = req_tdata[7:0];
                  want.y     = req_tdata[15:8];
                  want.red   = ch_out[0][15:0];
                  want.green = ch_out[1][15:0];
                  want.blue  = ch_out[2][15:0];
                  want.depth = depth;
                  pixel_queue.push_back(want);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected pixel %h", $time, got);
               errors++;
            end else begin
               want = pixel_queue.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: x expected %0d actual %0d", $time, want.x, got.x);
                  errors++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: y expected %0d actual %0d", $time, want.y, got.y);
                  errors++;
               end
               if (got.red !== want.red) begin
                  $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                  errors++;
               end
               if (got.green !== want.green) begin
                  $display("%0t: green expected %h actual %h", $time, want.green, got.green);
                  errors++;
               end
               if (got.blue !== want.blue) begin
                  $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                  errors++;
               end
               if (got.depth !== want.depth) begin
                  $display("%0t: depth expected %h actual %h", $time, want.depth, got.depth);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// File: tb/textured_blinn_phong_shader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_blinn_phong_shader_test
// Stimulus and verdict for the textured Blinn-Phong shader.
// ----------------------------------------------------------------------------
// Light items are sent as fragments of one or more lights, first a few
// directed corner cases, then random fragments over several register settings.
// The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module textured_blinn_phong_shader_test;

   // Longest stretch without any accepted item; it outlasts the depth clear
   // after reset and the receiver hold-off.
   localparam int STALL_LIMIT = 300000;
   localparam int HOLD_CYCLES = 6000;
   localparam int SETTLE      = 800;

   typedef struct {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] depth;
      logic [23:0] texel;
      logic [47:0] normal;
      logic [47:0] light;
      logic [47:0] half_vec;
      logic [1:0]  light_sel;
      logic        last;
   } light_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic [tbps_pkg::REQ_W-1:0]    req_tdata = '0;
   logic [1:0]                    req_tuser = '0;
   logic                          req_tlast = 1'b0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tbps_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          csr_we = 1'b0;
   logic [tbps_pkg::CSR_IW-1:0]   csr_index = '0;
   logic [tbps_pkg::CSR_W-1:0]    csr_wdata = '0;
   int                            errors;
   int                            pending;
   int                            quiet_cycles = 0;
   // Both sides stop idling while this is set.
   bit                            steady = 1'b0;
   // The receiver starts its long hold-off once this is set.
   bit                            hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   textured_blinn_phong_shader i_dut (
      .clock, .reset,
      .req_tdata, .req_tuser, .req_tlast, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready,
      .csr_we, .csr_index, .csr_wdata
   );

   shading_checker i_checker (
      .clock, .reset,
      .req_tdata, .req_tuser, .req_tlast, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .pending
   );

   // The watchdog ends a run that stops moving items on both channels.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("textured_blinn_phong_shader_test: FAIL");
         $finish;
      end
   end

   // Receiver: random back-pressure, one long hold-off on request, and no
   // back-pressure while the steady window is open.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 34);
         end
      end
   end

   // Offers one item, idling first at random, and returns in the step in
   // which it was accepted; valid stays high for a following item.
   task automatic send_light(input light_item_type it);
      while (!steady && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.half_vec, it.light, it.normal, it.texel, it.depth, it.y, it.x};
      req_tuser  <= it.light_sel;
      req_tlast  <= it.last;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
   endtask

   // Registers are written back to back, one per cycle.
   task automatic write_settings(input logic [47:0] l0, input logic [47:0] l1,
                                 input logic [47:0] l2, input logic [47:0] l3,
                                 input logic [47:0] spec, input logic [15:0] amb,
                                 input logic [7:0] shine);
      logic [47:0] vals[7];
      logic [tbps_pkg::CSR_IW-1:0] idx[7];
      vals = '{l0, l1, l2, l3, spec, 48'(amb), 48'(shine)};
      idx  = '{tbps_pkg::CSR_LIGHT0, tbps_pkg::CSR_LIGHT1, tbps_pkg::CSR_LIGHT2,
               tbps_pkg::CSR_LIGHT3, tbps_pkg::CSR_SPECULAR, tbps_pkg::CSR_AMBIENT,
               tbps_pkg::CSR_SHININESS};
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Lowers valid in the step of the last acceptance, waits for every pixel
   // and then lets a fragment that produced no pixel finish in the block.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535))};
   endfunction

   // Moderate components keep the vectors away from overflow most of the time.
   function automatic logic [47:0] moderate_vec();
      logic [47:0] v;
      for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($signed($urandom_range(16000)) - 8000);
      return v;
   endfunction

   function automatic logic [47:0] jitter(input logic [47:0] b);
      logic [47:0] v;
      for (int i = 0; i < 3; i++) begin
         v[16*i +: 16] = b[16*i +: 16] + 16'($signed($urandom_range(1023)) - 512);
      end
      return v;
   endfunction

   function automatic logic [47:0] negate(input logic [47:0] b);
      return {-b[47:32], -b[31:16], -b[15:0]};
   endfunction

   // A random light of a fragment: mostly lit surfaces with the half vector
   // near the normal, the rest raw noise, back-facing or degenerate vectors.
   function automatic light_item_type random_light(input light_item_type frag,
                                                   input bit last);
      light_item_type it;
      int kind;
      it = frag;
      it.last = last;
      it.light_sel = 2'($urandom_range(3));
      kind = $urandom_range(99);
      if (kind < 60) begin
         it.light    = jitter(it.normal);
         it.half_vec = jitter(it.normal);
      end else if (kind < 75) begin
         it.light    = moderate_vec();
         it.half_vec = moderate_vec();
      end else if (kind < 85) begin
         it.light    = negate(it.normal);
         it.half_vec = negate(jitter(it.normal));
      end else if (kind < 95) begin
         it.normal   = rand48();
         it.light    = rand48();
         it.half_vec = rand48();
      end else begin
         it.light    = '0;
         it.half_vec = (kind[0]) ? '0 : it.normal;
      end
      return it;
   endfunction

   function automatic light_item_type new_fragment();
      light_item_type f;
      // Most fragments land on a small patch so that the depth test matters.
      if ($urandom_range(9) < 8) begin
         f.x = 8'($urandom_range(7));
         f.y = 8'($urandom_range(7));
      end else begin
         f.x = 8'($urandom_range(255));
         f.y = 8'($urandom_range(255));
      end
      f.depth    = 16'($urandom_range(65535));
      f.texel    = {8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255))};
      f.normal   = moderate_vec();
      f.light    = '0;
      f.half_vec = '0;
      f.light_sel = '0;
      f.last     = 1'b0;
      return f;
   endfunction

   function automatic light_item_type corner(input logic [7:0] x, input logic [7:0] y,
                                             input logic [15:0] d, input logic [23:0] t,
                                             input logic [47:0] n, input logic [47:0] l,
                                             input logic [47:0] h, input logic [1:0] s,
                                             input bit last);
      light_item_type it;
      it = '{x, y, d, t, n, l, h, s, last};
      return it;
   endfunction

   initial begin
      light_item_type frag;
      light_item_type it;
      int sent;
      int lights;
      localparam logic [47:0] UP    = {16'sd16384, 16'sd0, 16'sd0};
      localparam logic [47:0] DOWN  = {-16'sd16384, 16'sd0, 16'sd0};
      localparam logic [47:0] MAXV  = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      localparam logic [47:0] MINV  = {16'h8000, 16'h8000, 16'h8000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_settings(48'h4000_8000_C000, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC,
                     48'h0001_0000_FFFF, 48'h8000_4000_2000, 16'h2000, 8'd8);

      // Directed corner cases.
      send_light(corner(8'd0, 8'd0, 16'd0, 24'hFFFFFF, UP, UP, UP, 2'd0, 1'b1));
      // A second hit at the same place and depth fails the strict test.
      send_light(corner(8'd0, 8'd0, 16'd0, 24'hFFFFFF, UP, UP, UP, 2'd1, 1'b1));
      // The farthest depth never passes against a cleared buffer.
      send_light(corner(8'd255, 8'd255, 16'hFFFF, 24'h808080, UP, UP, UP, 2'd2, 1'b1));
      send_light(corner(8'd255, 8'd255, 16'hFFFE, 24'h000000, MAXV, MAXV, MAXV, 2'd3, 1'b1));
      // Zero-length vectors shade to ambient only; the next item has extreme components.
      send_light(corner(8'd1, 8'd0, 16'd100, 24'h0000FF, '0, '0, '0, 2'd0, 1'b1));
      send_light(corner(8'd0, 8'd1, 16'd100, 24'h00FF00, MINV, MINV, MAXV, 2'd1, 1'b1));
      // A back-facing light drives the sum negative and the half vector
      // facing away drops the highlight.
      send_light(corner(8'd2, 8'd0, 16'd50, 24'hFF00FF, UP, DOWN, DOWN, 2'd1, 1'b0));
      send_light(corner(8'd2, 8'd0, 16'd50, 24'hFF00FF, UP, DOWN, DOWN, 2'd2, 1'b1));
      // Four lights in one fragment, last one closes it.
      send_light(corner(8'd3, 8'd3, 16'd7, 24'h102030, UP, UP, UP, 2'd0, 1'b0));
      send_light(corner(8'd3, 8'd3, 16'd7, 24'h102030, MAXV, UP, MAXV, 2'd1, 1'b0));
      send_light(corner(8'd3, 8'd3, 16'd7, 24'h102030, MINV, DOWN, UP, 2'd2, 1'b0));
      send_light(corner(8'd3, 8'd3, 16'd7, 24'hABCDEF, UP, MAXV, UP, 2'd3, 1'b1));
      // Tiny vectors whose components are at most one count.
      send_light(corner(8'd4, 8'd4, 16'd1, 24'hFFFFFF, 48'h0000_0000_0001,
                        48'h0000_0000_0001, 48'h0000_0000_0001, 2'd1, 1'b1));
      send_light(corner(8'd5, 8'd5, 16'd2, 24'h55AA55, 48'hFFFF_FFFF_FFFF,
                        48'h0001_0001_0001, 48'hFFFF_FFFF_FFFF, 2'd1, 1'b1));
      drain();

      // Several settings, the extremes among them, each with random fragments.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_settings(rand48(), rand48(), rand48(), rand48(), rand48(),
                              16'($urandom_range(65535)), 8'd32);
            1: write_settings('1, '1, '1, '1, '1, 16'hFFFF, 8'd255);
            2: write_settings('0, '0, '0, '0, '0, 16'h0000, 8'd1);
            3: write_settings(rand48(), rand48(), 48'hFFFF_FFFF_FFFF, '0, rand48(),
                              16'h8000, 8'($urandom_range(255, 1)));
            default: write_settings(rand48(), rand48(), rand48(), rand48(), rand48(),
                                    16'($urandom_range(65535)),
                                    8'($urandom_range(255, 1)));
         endcase
         sent = 0;
         while (sent < 305) begin
            frag = new_fragment();
            // Now and then a long fragment runs the sums into saturation.
            lights = ($urandom_range(19) == 0) ? $urandom_range(40, 18) : $urandom_range(4, 1);
            for (int i = 0; i < lights; i++) begin
               it = random_light(frag, i == lights - 1);
               send_light(it);
               sent++;
            end
            if (phase == 1 && sent > 40) hold_request = 1'b1;
            steady = (phase == 3 && sent > 100 && sent < 220);
         end
         drain();
      end

      if (errors == 0) begin
         $display("textured_blinn_phong_shader_test: PASS");
      end else begin
         $display("textured_blinn_phong_shader_test: FAIL");
      end
      $finish;
   end

endmodule
